/* rtl/icb_pkg.sv */
// ============================================================================
// icb_pkg: shared types and constants for the clamped-border convolution
// Holds the tap control bundle passed from the address sequencer to the
// multiply-accumulate unit, and the fixed datapath widths.
// ============================================================================
`default_nettype none

package icb_pkg;

    // Grey pixel and Q8.8 coefficient widths
    localparam int PIX_W  = 8;
    localparam int COEF_W = 16;

    // Product of an unsigned pixel and a signed coefficient
    localparam int PROD_W = PIX_W + COEF_W + 1;

    // Accumulator: 15x15 taps of full-scale products stay well inside this
    localparam int ACC_W  = 34;

    // Rounded, wrapped result
    localparam int OUT_W  = 22;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // Control that travels with one kernel tap
    typedef struct packed {
        logic tap;    // beat carries a kernel tap
        logic first;  // first tap of the window: restart the sum
        logic last;   // last tap of the window: finish the sum
        logic zero;   // empty window: contribute nothing
    } tap_ctl_t;

endpackage

`default_nettype wire

/* rtl/icb_mac.sv */
// ============================================================================
// icb_mac: multiply-accumulate and rounding unit
// Multiplies each pixel by its coefficient, sums the window, then rounds the
// Q8.8 sum half away from zero and wraps it to the result width.
// ============================================================================
`default_nettype none

module icb_mac
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire icb_pkg::tap_ctl_t                   ctl,
    input  wire logic        [icb_pkg::PIX_W-1:0]    pix,
    input  wire logic signed [icb_pkg::COEF_W-1:0]   coef,
    output logic                                     done,
    output logic signed      [icb_pkg::OUT_W-1:0]    result
);

    icb_pkg::tap_ctl_t          ctl1_reg;
    icb_pkg::prod_t             prod_reg;
    logic                       sum_vld_reg;
    icb_pkg::acc_t              acc_reg;
    logic                       mag_vld_reg;
    logic                       neg_reg;
    logic [icb_pkg::ACC_W-1:0]  mag_reg;
    logic                       q_vld_reg;
    logic                       q_neg_reg;
    logic [icb_pkg::ACC_W-1:0]  q_reg;
    logic                       done_reg;
    logic signed [icb_pkg::OUT_W-1:0] result_reg;

    // Advance the valid flags of each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg    <= '0;
            sum_vld_reg <= 1'b0;
            mag_vld_reg <= 1'b0;
            q_vld_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            ctl1_reg    <= ctl;
            sum_vld_reg <= ctl1_reg.tap && ctl1_reg.last;
            mag_vld_reg <= sum_vld_reg;
            q_vld_reg   <= mag_vld_reg;
            done_reg    <= q_vld_reg;
        end
    end

    // Multiply, accumulate, take magnitude, round, restore sign
    always_ff @(posedge clk)
    begin
        if (ctl.zero)
        begin
            prod_reg <= '0;
        end
        else
        begin
            prod_reg <= $signed({1'b0, pix}) * coef;
        end

        if (ctl1_reg.tap)
        begin
            if (ctl1_reg.first)
            begin
                acc_reg <= icb_pkg::acc_t'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + icb_pkg::acc_t'(prod_reg);
            end
        end

        neg_reg <= acc_reg[icb_pkg::ACC_W-1];
        mag_reg <= acc_reg[icb_pkg::ACC_W-1] ? icb_pkg::ACC_W'(-acc_reg)
                                             : icb_pkg::ACC_W'(acc_reg);

        q_neg_reg <= neg_reg;
        q_reg     <= (mag_reg + icb_pkg::ACC_W'(128)) >> 8;

        result_reg <= q_neg_reg ? icb_pkg::OUT_W'(icb_pkg::ACC_W'(0) - q_reg)
                                : icb_pkg::OUT_W'(q_reg);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/image_convolution_clamped_border.sv */
// ============================================================================
// image_convolution_clamped_border: 2-D convolution with replicated borders
// Loads Q8.8 kernel coefficients and 8-bit pixels into on-chip memories and
// returns one rounded, unsaturated filtered pixel per compute beat.
// ============================================================================
//
//  Channel | Signals                                   | Beat taken when
//  --------+-------------------------------------------+---------------------
//  cfg     | cfg_we, cfg_index, cfg_data               | cfg_we high
//  in      | in_valid, in_ready, opcode, row_index,    | in_valid & in_ready
//          | col_index, pixel_value, coef_value        |
//  out     | out_valid, out_ready, filtered_value      | out_valid & out_ready
//
//  Load beats write straight into the frame or coefficient memory.
//  A compute beat issues one tap per cycle through the single read port of
//  the frame memory (a single zero tap for an empty window), then passes
//  through the multiply, sum and rounding stages.
//  Reset clears control state only; the memories need no clearing pass.
//  A waiting result sits in the output register; load beats keep flowing
//  behind it and a new compute stalls only at its final hand-off.
// ============================================================================
`default_nettype none

module image_convolution_clamped_border
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_KERNEL = 7
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic        [1:0]                   cfg_index,
    input  wire logic        [9:0]                   cfg_data,
    // input beats
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [1:0]                   opcode,
    input  wire logic        [8:0]                   row_index,
    input  wire logic        [8:0]                   col_index,
    input  wire logic        [icb_pkg::PIX_W-1:0]    pixel_value,
    input  wire logic signed [icb_pkg::COEF_W-1:0]   coef_value,
    // result beats
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [icb_pkg::OUT_W-1:0]    filtered_value
);

    // Derived widths
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int FD   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = (FD > 1) ? $clog2(FD) : 1;
    localparam int KD   = MAX_KERNEL * MAX_KERNEL;
    localparam int KAW  = (KD > 1) ? $clog2(KD) : 1;
    localparam int KW   = $clog2(MAX_KERNEL + 1);
    localparam int TW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CRDW = 12;

    // Input opcodes
    localparam logic [1:0] OP_LOAD_COEF  = 2'd0;
    localparam logic [1:0] OP_LOAD_PIXEL = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_KERNEL_SIZE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef logic signed [CRDW-1:0] coord_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_PUT
    } state_t;

    // Configuration registers
    logic [2:0]  kernel_size_reg;
    logic [9:0]  image_width_reg;
    logic [9:0]  image_height_reg;

    // Sequencer state and latched operands
    state_t      state_reg;
    logic [TW-1:0] i_reg;
    logic [TW-1:0] j_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] half_reg;
    logic [8:0]  row_reg;
    logic [8:0]  col_reg;
    logic [9:0]  w_hi_reg;
    logic [9:0]  h_hi_reg;
    logic        out_valid_reg;
    logic signed [icb_pkg::OUT_W-1:0] out_data_reg;
    logic signed [icb_pkg::OUT_W-1:0] hold_reg;

    // Address stage and read stage
    icb_pkg::tap_ctl_t tap_next;
    icb_pkg::tap_ctl_t tap_a_reg;
    icb_pkg::tap_ctl_t tap_b_reg;
    logic [RW-1:0]  sr_next;
    logic [CW-1:0]  sc_next;
    logic [RW-1:0]  sr_reg;
    logic [CW-1:0]  sc_reg;
    logic [KAW-1:0] caddr_reg;

    // Memories
    logic [icb_pkg::PIX_W-1:0]         frame_mem [FD];
    logic signed [icb_pkg::COEF_W-1:0] coef_mem  [KD];
    logic [icb_pkg::PIX_W-1:0]         pix_rd_reg;
    logic signed [icb_pkg::COEF_W-1:0] coef_rd_reg;

    logic          in_fire;
    logic          pix_we;
    logic          coef_we;
    logic [AW-1:0] pix_wr_addr;
    logic [AW-1:0] pix_rd_addr;
    logic [KAW-1:0] coef_wr_addr;
    logic [KW-1:0] k_eff;
    logic [9:0]    w_hi;
    logic [9:0]    h_hi;
    logic          last_col;
    logic          last_tap;
    coord_t        sr_raw;
    coord_t        sc_raw;
    logic          mac_done;
    logic signed [icb_pkg::OUT_W-1:0] mac_result;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign filtered_value = out_data_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_size_reg  <= 3'd3;
            image_width_reg  <= 10'd512;
            image_height_reg <= 10'd512;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KERNEL_SIZE:  kernel_size_reg  <= cfg_data[2:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective kernel side and clamp limits for a new compute beat
    always_comb
    begin
        if (int'(kernel_size_reg) > MAX_KERNEL)
        begin
            k_eff = KW'(MAX_KERNEL);
        end
        else
        begin
            k_eff = KW'(kernel_size_reg);
        end

        if (image_width_reg == 10'd0)
        begin
            w_hi = 10'd0;
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            w_hi = 10'(MAX_WIDTH - 1);
        end
        else
        begin
            w_hi = image_width_reg - 10'd1;
        end

        if (image_height_reg == 10'd0)
        begin
            h_hi = 10'd0;
        end
        else if (int'(image_height_reg) > MAX_HEIGHT)
        begin
            h_hi = 10'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_hi = image_height_reg - 10'd1;
        end
    end

    // Form the current tap and its clamped source coordinates
    always_comb
    begin
        last_col = (int'(j_reg) == int'(k_reg) - 1);
        last_tap = (k_reg == '0) || (last_col && (int'(i_reg) == int'(k_reg) - 1));

        tap_next.tap   = (state_reg == S_RUN);
        tap_next.first = (i_reg == '0) && (j_reg == '0);
        tap_next.last  = last_tap;
        tap_next.zero  = (k_reg == '0);

        sr_raw = coord_t'(row_reg) + coord_t'(i_reg) - coord_t'(half_reg);
        sc_raw = coord_t'(col_reg) + coord_t'(j_reg) - coord_t'(half_reg);

        if (sr_raw < 0)
        begin
            sr_next = '0;
        end
        else if (sr_raw > coord_t'(h_hi_reg))
        begin
            sr_next = RW'(h_hi_reg);
        end
        else
        begin
            sr_next = RW'(sr_raw);
        end

        if (sc_raw < 0)
        begin
            sc_next = '0;
        end
        else if (sc_raw > coord_t'(w_hi_reg))
        begin
            sc_next = CW'(w_hi_reg);
        end
        else
        begin
            sc_next = CW'(sc_raw);
        end
    end

    // Register tap control and addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_a_reg <= '0;
            tap_b_reg <= '0;
        end
        else
        begin
            tap_a_reg <= tap_next;
            tap_b_reg <= tap_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg    <= sr_next;
        sc_reg    <= sc_next;
        caddr_reg <= KAW'(int'(i_reg) * MAX_KERNEL + int'(j_reg));
    end

    // Memory ports: one write from the input, one registered read per tap
    assign pix_we  = in_fire && (opcode == OP_LOAD_PIXEL) &&
                     (int'(row_index) < MAX_HEIGHT) && (int'(col_index) < MAX_WIDTH);
    assign coef_we = in_fire && (opcode == OP_LOAD_COEF) &&
                     (int'(row_index) < MAX_KERNEL) && (int'(col_index) < MAX_KERNEL);
    assign pix_wr_addr  = AW'(int'(row_index) * MAX_WIDTH + int'(col_index));
    assign pix_rd_addr  = AW'(int'(sr_reg) * MAX_WIDTH + int'(sc_reg));
    assign coef_wr_addr = KAW'(int'(row_index) * MAX_KERNEL + int'(col_index));

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            frame_mem[pix_wr_addr] <= pixel_value;
        end
        pix_rd_reg <= frame_mem[pix_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_wr_addr] <= coef_value;
        end
        coef_rd_reg <= coef_mem[caddr_reg];
    end

    // Multiply, sum and round the window
    icb_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (tap_b_reg),
        .pix    (pix_rd_reg),
        .coef   (coef_rd_reg),
        .done   (mac_done),
        .result (mac_result)
    );

    // Sequence taps and hand the result to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop a taken beat unless the hand-off below replaces it
            if (out_valid_reg && out_ready && (state_reg != S_PUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && (opcode == OP_COMPUTE))
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= k_eff;
                        half_reg  <= KW'((int'(k_eff) + 1) >> 1);
                        row_reg   <= row_index;
                        col_reg   <= col_index;
                        w_hi_reg  <= w_hi;
                        h_hi_reg  <= h_hi;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (last_tap)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else if (last_col)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + TW'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + TW'(1);
                    end
                end
                S_WAIT:
                begin
                    if (mac_done)
                    begin
                        hold_reg  <= mac_result;
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= hold_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A finished window arrives only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_WAIT))
        else $error("icb: window result outside wait state");

    // Taps enter the read stage only from the run state
    assert property (@(posedge clk) disable iff (!rst_n)
        tap_a_reg.tap |-> $past(state_reg == S_RUN))
        else $error("icb: tap issued outside run state");

    // Clamped source row stays inside the image
    assert property (@(posedge clk) disable iff (!rst_n)
        tap_a_reg.tap |-> (int'(sr_reg) <= int'(h_hi_reg)))
        else $error("icb: source row beyond image");

    // Clamped source column stays inside the image
    assert property (@(posedge clk) disable iff (!rst_n)
        tap_a_reg.tap |-> (int'(sc_reg) <= int'(w_hi_reg)))
        else $error("icb: source column beyond image");
`endif

endmodule

`default_nettype wire
